/* hdl/mwp_pkg.sv */
// shared types and constants of the 3x3 material window packer
package mwp_pkg;

  localparam int NIB_W      = 4;
  localparam int NIBS       = 9;
  localparam int WIN_W      = NIB_W * NIBS;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CQ_DEPTH   = 4;
  localparam int RQ_DEPTH   = 4;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_MATERIAL = 2'd2;

  localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 11'd1024;
  localparam logic [NIB_W-1:0]      BORDER_RESET    = 4'h0;

  // request opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  typedef struct packed {
    logic             op;
    logic [NIB_W-1:0] material;
  } in_item_t;

  typedef struct packed {
    logic [WIN_W-1:0] neighborhood;
    logic             frame_last;
  } out_item_t;

  // classified request handed from the front to the back
  typedef struct packed {
    logic             drain;
    logic [NIB_W-1:0] material;
    logic             start;
    logic             emit_center;
    logic             emit_edge;
    logic             left_center;
    logic             left_edge;
    logic             top_row;
    logic             in_left;
    logic             in_right;
    logic             two_rows;
    logic             last;
  } cmd_t;

endpackage

/* hdl/mwp_front.sv */
// front end: configuration registers, raster counters and request classification
module mwp_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mwp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mwp_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 push,
  input  mwp_pkg::in_item_t                    item,
  input  logic                                 full,
  output logic                                 cmd_push,
  output mwp_pkg::cmd_t                        cmd,
  output logic [AW-1:0]                        cmd_col,
  output logic [mwp_pkg::NIB_W-1:0]            border
);
  import mwp_pkg::*;

  localparam int CWW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int CHW = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] grid_width, grid_width_next;
  logic [CFG_DATA_W-1:0] grid_height, grid_height_next;
  logic [NIB_W-1:0]      border_material, border_material_next;
  logic [AW-1:0]         column_count, column_count_next;
  logic [HW-1:0]         row_count, row_count_next;
  logic [AW-1:0]         drain_count, drain_count_next;

  logic [CWW-1:0] width_ext;
  logic [CHW-1:0] height_ext;
  logic [WW-1:0]  width_eff, width_m1;
  logic [HW-1:0]  height_eff;
  logic           accept, frame_done, last_col, drain_last, restart;

  assign cfg_ready = 1'b1;
  assign border    = border_material;

  always_comb begin
    // sizes clamped to 1..max
    width_ext  = CWW'(grid_width);
    height_ext = CHW'(grid_height);
    if (width_ext == '0) begin
      width_eff = WW'(1);
    end else if (width_ext > CWW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(width_ext);
    end
    if (height_ext == '0) begin
      height_eff = HW'(1);
    end else if (height_ext > CHW'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(height_ext);
    end
    width_m1   = width_eff - WW'(1);
    last_col   = (WW'(column_count) == width_m1);
    drain_last = (WW'(drain_count) == width_m1);
    frame_done = (row_count >= height_eff);
    accept     = push && !full;

    cmd          = '0;
    cmd.material = item.material;
    cmd_col      = column_count;
    cmd_push     = 1'b0;
    restart      = 1'b0;

    grid_width_next      = grid_width;
    grid_height_next     = grid_height;
    border_material_next = border_material;
    column_count_next    = column_count;
    row_count_next       = row_count;
    drain_count_next     = drain_count;

    if (item.op == OP_DRAIN) begin
      cmd.drain    = 1'b1;
      cmd.in_left  = (drain_count != '0);
      cmd.in_right = !drain_last;
      cmd.two_rows = (height_eff != HW'(1));
      cmd.last     = drain_last;
      cmd_col      = drain_count;
      cmd_push     = accept && frame_done;
      if (cmd_push) begin
        drain_count_next = drain_count + AW'(1);
        restart          = drain_last;
      end
    end else begin
      cmd.start       = (column_count == '0) && (row_count == '0);
      cmd.emit_center = (row_count != '0) && (column_count != '0);
      cmd.emit_edge   = (row_count != '0) && last_col;
      cmd.left_center = (column_count == AW'(1));
      cmd.left_edge   = (column_count == '0);
      cmd.top_row     = (row_count == HW'(1));
      cmd_push        = accept && !frame_done;
      if (cmd_push) begin
        if (last_col) begin
          column_count_next = '0;
          row_count_next    = row_count + HW'(1);
        end else begin
          column_count_next = column_count + AW'(1);
        end
      end
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH: begin
          grid_width_next = cfg_data;
          restart         = 1'b1;
        end
        REG_GRID_HEIGHT: begin
          grid_height_next = cfg_data;
          restart          = 1'b1;
        end
        REG_BORDER_MATERIAL: begin
          border_material_next = cfg_data[NIB_W-1:0];
          restart              = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (restart) begin
      column_count_next = '0;
      row_count_next    = '0;
      drain_count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width      <= GRID_SIZE_RESET;
      grid_height     <= GRID_SIZE_RESET;
      border_material <= BORDER_RESET;
      column_count    <= '0;
      row_count       <= '0;
      drain_count     <= '0;
    end else begin
      grid_width      <= grid_width_next;
      grid_height     <= grid_height_next;
      border_material <= border_material_next;
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      drain_count     <= drain_count_next;
    end
  end

endmodule

/* hdl/mwp_cmd_fifo.sv */
// small request queue between the front and the back
module mwp_cmd_fifo #(
  parameter int DATA_W = 24,
  localparam int PW = $clog2(mwp_pkg::CQ_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              empty,
  output logic [DATA_W-1:0] rd_data
);
  import mwp_pkg::*;

  logic [DATA_W-1:0] slots [CQ_DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [PW:0]       count;
  logic              do_wr, do_rd;

  assign full    = (count == (PW+1)'(CQ_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(do_wr);
      rd_ptr <= rd_ptr + PW'(do_rd);
      count  <= count + (PW+1)'(do_wr) - (PW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

/* hdl/mwp_back.sv */
// back end: line buffer memory, window register and result assembly
module mwp_back #(
  parameter int MAX_WIDTH = 1024,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  mwp_pkg::cmd_t             cmd,
  input  logic [AW-1:0]             cmd_col,
  output logic                      cmd_pop,
  input  logic [mwp_pkg::NIB_W-1:0] border,
  input  logic                      room,
  output logic [1:0]                res_push,
  output mwp_pkg::out_item_t        res0,
  output mwp_pkg::out_item_t        res1
);
  import mwp_pkg::*;

  localparam int ENT_W = 2 * NIB_W;

  // entry: upper nibble = row two above, lower nibble = row above
  logic [ENT_W-1:0] line_mem [MAX_WIDTH];

  logic             s2_valid;
  cmd_t             s2_cmd;
  logic [AW-1:0]    s2_col;
  logic [ENT_W-1:0] rd_a, rd_b, fwd_data, drain_left;
  logic             fwd_a_hit, fwd_b_hit;
  logic [WIN_W-1:0] window;

  logic             finish, advance, wr_en;
  logic [AW-1:0]    addr_b;
  logic [ENT_W-1:0] cur_a, cur_b, wr_data;
  logic [WIN_W-1:0] old_win, new_win, edge_cells, center_res, edge_res;
  logic [WIN_W-1:0] drain_res;
  logic [ENT_W-1:0] ent [3];
  logic [2:0]       col_in;

  function automatic logic [WIN_W-1:0] mask_border(input logic [WIN_W-1:0] cells,
                                                    input logic left_out,
                                                    input logic top_out,
                                                    input logic right_out,
                                                    input logic [NIB_W-1:0] code);
    logic [WIN_W-1:0] res;
    res = cells;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((left_out && c == 0) || (right_out && c == 2) || (top_out && r == 0)) begin
          res[(r*3+c)*NIB_W +: NIB_W] = code;
        end
      end
    end
    return res;
  endfunction

  always_comb begin
    finish  = s2_valid && room;
    advance = cmd_valid && (!s2_valid || finish);
    cmd_pop = advance;
    addr_b  = (cmd_col == AW'(MAX_WIDTH - 1)) ? '0 : cmd_col + AW'(1);

    cur_a   = fwd_a_hit ? fwd_data : rd_a;
    cur_b   = fwd_b_hit ? fwd_data : rd_b;
    wr_en   = finish && !s2_cmd.drain;
    wr_data = {cur_a[NIB_W-1:0], s2_cmd.material};

    // window shifts one column left, fresh column enters on the right
    old_win = s2_cmd.start ? '0 : window;
    for (int r = 0; r < 3; r++) begin
      new_win[(r*3)*NIB_W +: NIB_W]      = old_win[(r*3+1)*NIB_W +: NIB_W];
      new_win[(r*3+1)*NIB_W +: NIB_W]    = old_win[(r*3+2)*NIB_W +: NIB_W];
    end
    new_win[2*NIB_W +: NIB_W] = cur_a[ENT_W-1:NIB_W];
    new_win[5*NIB_W +: NIB_W] = cur_a[NIB_W-1:0];
    new_win[8*NIB_W +: NIB_W] = s2_cmd.material;

    // row end: the two newest columns, right neighbours outside
    for (int r = 0; r < 3; r++) begin
      edge_cells[(r*3)*NIB_W +: NIB_W]   = new_win[(r*3+1)*NIB_W +: NIB_W];
      edge_cells[(r*3+1)*NIB_W +: NIB_W] = new_win[(r*3+2)*NIB_W +: NIB_W];
      edge_cells[(r*3+2)*NIB_W +: NIB_W] = '0;
    end

    center_res = mask_border(new_win, s2_cmd.left_center, s2_cmd.top_row, 1'b0, border);
    edge_res   = mask_border(edge_cells, s2_cmd.left_edge, s2_cmd.top_row, 1'b1, border);

    // drain: last two rows read back from the line buffer, bottom row is border
    ent[0] = drain_left;
    ent[1] = cur_a;
    ent[2] = cur_b;
    col_in = {s2_cmd.in_right, 1'b1, s2_cmd.in_left};
    for (int dx = 0; dx < 3; dx++) begin
      drain_res[dx*NIB_W +: NIB_W] =
        (col_in[dx] && s2_cmd.two_rows) ? ent[dx][ENT_W-1:NIB_W] : border;
      drain_res[(3+dx)*NIB_W +: NIB_W] = col_in[dx] ? ent[dx][NIB_W-1:0] : border;
      drain_res[(6+dx)*NIB_W +: NIB_W] = border;
    end

    res_push[0] = finish && (s2_cmd.drain || s2_cmd.emit_center || s2_cmd.emit_edge);
    res_push[1] = finish && !s2_cmd.drain && s2_cmd.emit_center && s2_cmd.emit_edge;
    if (s2_cmd.drain) begin
      res0.neighborhood = drain_res;
    end else if (s2_cmd.emit_center) begin
      res0.neighborhood = center_res;
    end else begin
      res0.neighborhood = edge_res;
    end
    res0.frame_last   = s2_cmd.drain && s2_cmd.last;
    res1.neighborhood = edge_res;
    res1.frame_last   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= advance || (s2_valid && !finish);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_cmd    <= cmd;
      s2_col    <= cmd_col;
      rd_a      <= line_mem[cmd_col];
      rd_b      <= line_mem[addr_b];
      fwd_a_hit <= wr_en && (s2_col == cmd_col);
      fwd_b_hit <= wr_en && (s2_col == addr_b);
      fwd_data  <= wr_data;
    end
    if (wr_en) begin
      line_mem[s2_col] <= wr_data;
      window           <= new_win;
    end
    if (finish && s2_cmd.drain) begin
      drain_left <= cur_a;
    end
  end

endmodule

/* hdl/mwp_result_queue.sv */
// result queue, takes up to two results per cycle
module mwp_result_queue #(
  localparam int PW = $clog2(mwp_pkg::RQ_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         push,
  input  mwp_pkg::out_item_t data0,
  input  mwp_pkg::out_item_t data1,
  output logic               room,
  output logic               empty,
  input  logic               pop,
  output mwp_pkg::out_item_t head
);
  import mwp_pkg::*;

  out_item_t     slots [RQ_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_pop;

  assign empty  = (count == '0);
  assign room   = (count <= (PW+1)'(RQ_DEPTH - 2));
  assign head   = slots[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push[0]) + PW'(push[1]);
      rd_ptr <= rd_ptr + PW'(do_pop);
      count  <= count + (PW+1)'(push[0]) + (PW+1)'(push[1]) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push[0]) begin
      slots[wr_ptr] <= data0;
    end
    if (push[1]) begin
      slots[wr_ptr + PW'(1)] <= data1;
    end
  end

endmodule

/* hdl/material_window_packer_3x3.sv */
// top level of the 3x3 material window packer
// Takes a grid of 4-bit material codes in raster order (op = sample) and gives
// for each cell its 3x3 neighbourhood as nine nibbles, nibble k = (dy+1)*3+(dx+1);
// neighbours outside the grid read as border_material. The result for a cell
// comes out when the cell one row down and one column right is pushed, so a
// sample at the end of a row gives two results; once the frame is complete,
// drain requests (op = drain) flush the last row one result each, and the
// final result carries frame_last. Out-of-frame samples and early drains are
// dropped without a result. Throughput is one request per clock unless the request
// queue is full or the result queue lacks room: the front classifies a request in
// the cycle it is accepted, the back reads up to two line buffer entries and writes
// one per cycle, and a two-entry write into the result queue covers the double
// result at a row end. A result passes the request queue, back stage register and
// result queue. Both stored rows share one line buffer memory of MAX_WIDTH entries,
// eight bits wide, with two read ports (the second one serves drain); it has no
// clearing pass and entries never written read as whatever they hold. A register
// write restarts the frame; any configuration write is only legal while idle.
module material_window_packer_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mwp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwp_pkg::CFG_DATA_W-1:0] cfg_data,
  // request side
  input  logic                           push,
  output logic                           full,
  input  mwp_pkg::in_item_t              item,
  // result side
  output logic                           empty,
  input  logic                           pop,
  output mwp_pkg::out_item_t             result
);
  import mwp_pkg::*;

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMD_W = $bits(cmd_t) + AW;

  // front to queue
  logic             f_push;
  cmd_t             f_cmd;
  logic [AW-1:0]    f_col;
  logic [NIB_W-1:0] border;

  // queue to back
  logic [CMD_W-1:0] q_data;
  logic             q_empty, q_pop;
  cmd_t             q_cmd;
  logic [AW-1:0]    q_col;

  // back to result queue
  logic [1:0]       res_push;
  out_item_t        res0, res1;
  logic             res_room;

  assign q_cmd = cmd_t'(q_data[CMD_W-1:AW]);
  assign q_col = q_data[AW-1:0];

  // config registers, raster position, classification of each request
  mwp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_push  (f_push),
    .cmd       (f_cmd),
    .cmd_col   (f_col),
    .border    (border)
  );

  // decouples the front from back stalls; its full is the block's full
  mwp_cmd_fifo #(
    .DATA_W (CMD_W)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_data ({f_cmd, f_col}),
    .full    (full),
    .rd_en   (q_pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  // line buffer, window and result assembly
  mwp_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd       (q_cmd),
    .cmd_col   (q_col),
    .cmd_pop   (q_pop),
    .border    (border),
    .room      (res_room),
    .res_push  (res_push),
    .res0      (res0),
    .res1      (res1)
  );

  // output register stage, oldest result on the ports
  mwp_result_queue u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .data0 (res0),
    .data1 (res1),
    .room  (res_room),
    .empty (empty),
    .pop   (pop),
    .head  (result)
  );

endmodule
